// ----- sv/separable_convolution_2d_macros.svh -----
// Assertion macros shared by the checker of the separable convolution block.
`ifndef SEPARABLE_CONVOLUTION_2D_MACROS_SVH
`define SEPARABLE_CONVOLUTION_2D_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SC2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SC2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sc2d_pkg.sv -----
// Package with sizes, types and register codes of the separable convolution block.
`timescale 1ns / 1ps

package sc2d_pkg;

    localparam int MAX_RADIUS = 4;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 16;
    localparam int TAP_W  = 8;
    localparam int VAL_W  = 38;
    localparam int RAD_W  = 3;
    localparam int SIZE_W = 11;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    localparam int TAP_NUM    = 2 * MAX_RADIUS + 1;
    localparam int WIN_DEPTH  = TAP_NUM;
    localparam int LINE_SLOTS = 2 * MAX_RADIUS;
    localparam int SLOT_W     = $clog2(LINE_SLOTS);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
    localparam int M_W        = $clog2(MAX_RADIUS + 1);

    localparam int PROD_W = PIX_W + TAP_W + 1;
    localparam int RF_W   = PIX_W + TAP_W + $clog2(TAP_NUM);
    localparam int CP_W   = RF_W + TAP_W;

    typedef enum logic [IDX_W-1:0] {
        REG_RADIUS    = 3'd0,
        REG_WIDTH     = 3'd1,
        REG_HEIGHT    = 3'd2,
        REG_TAPS_LO   = 3'd3,
        REG_TAP_EIGHT = 3'd4
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]                  pixel_t;
    typedef logic [WIN_DEPTH-1:0][PIX_W-1:0]   window_t;
    typedef logic [TAP_NUM-1:0][TAP_W-1:0]     taps_t;
    typedef logic signed [RF_W-1:0]            rf_t;
    typedef logic [LINE_SLOTS-1:0][RF_W-1:0]   linedata_t;

    // Effective (clamped) frame geometry.
    typedef struct packed {
        logic [M_W-1:0]   rad;
        logic [WID_W-1:0] wid;
        logic [HGT_W-1:0] hgt;
    } geom_t;

    // One pass of the row filter and the column sum that follows it.
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             wr;
        logic             cur;
        logic             last;
        logic [M_W-1:0]   m;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] row;
        logic [SLOT_W-1:0] slot;
    } op_t;

endpackage

// ----- sv/separable_convolution_2d.sv -----
// Top level of the streaming separable 2-D convolution with zero padding.
`timescale 1ns / 1ps

// Pixels enter in raster order, one beat per cycle while pix_stall is low, and
// each is row filtered and then column filtered with the same signed kernel of
// 2R+1 taps; samples outside the frame count as zero. At the last pixel of a
// row the single row-filter unit produces the trailing R outputs of the row
// one per cycle while the pipeline moves, with pix_stall held high. After the
// frame, send R*width drain beats; each stands for a row below the image and
// gives one result if that row is at least R. A result is registered after the
// row products, the line read and the column products of its pass. Row-filtered
// lines live in 2*MAX_RADIUS banks of MAX_WIDTH entries, one bank per line, all
// read at the same column in the same cycle. Line entries are only read after
// they have been written, so the banks need no clearing after reset. Whenever
// a result waits with res_stall high, the whole pipeline holds and pix_stall is
// high. Configuration may only be written while the block is idle.
module separable_convolution_2d import sc2d_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    pix_valid,
    output logic                    pix_stall,
    input  logic [PIX_W-1:0]        pixel,
    input  logic                    drain,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic signed [VAL_W-1:0] value,
    output logic                    last
);

    logic [RAD_W-1:0]  rad_reg;
    logic [SIZE_W-1:0] wid_reg;
    logic [SIZE_W-1:0] hgt_reg;
    logic [CFG_W-1:0]  taps_lo_reg;
    logic [TAP_W-1:0]  tap8_reg;

    geom_t     geom;
    taps_t     taps;
    logic      adv;
    op_t       op_a, op_b;
    window_t   window;
    rf_t       rf;
    linedata_t line;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg     <= RAD_W'(1);
            wid_reg     <= SIZE_W'(1024);
            hgt_reg     <= SIZE_W'(1024);
            taps_lo_reg <= '0;
            tap8_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS:    rad_reg     <= cfg_data[RAD_W-1:0];
                REG_WIDTH:     wid_reg     <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:    hgt_reg     <= cfg_data[SIZE_W-1:0];
                REG_TAPS_LO:   taps_lo_reg <= cfg_data;
                REG_TAP_EIGHT: tap8_reg    <= cfg_data[TAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // Out-of-range sizes are clamped here, so the datapath only sees legal values.
    always_comb
    begin
        geom.rad = (int'(rad_reg) > MAX_RADIUS) ? M_W'(MAX_RADIUS) : M_W'(rad_reg);
        if (wid_reg == '0)
        begin
            geom.wid = WID_W'(1);
        end
        else if (int'(wid_reg) > MAX_WIDTH)
        begin
            geom.wid = WID_W'(MAX_WIDTH);
        end
        else
        begin
            geom.wid = WID_W'(wid_reg);
        end
        if (hgt_reg == '0)
        begin
            geom.hgt = HGT_W'(1);
        end
        else if (int'(hgt_reg) > MAX_HEIGHT)
        begin
            geom.hgt = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            geom.hgt = HGT_W'(hgt_reg);
        end
    end

    // Taps above the ninth read as zero.
    for (genvar i = 0; i < TAP_NUM; i++)
    begin : g_tap
        if (i < 8)
        begin : g_lo
            assign taps[i] = taps_lo_reg[8*i +: TAP_W];
        end
        else if (i == 8)
        begin : g_eight
            assign taps[i] = tap8_reg;
        end
        else
        begin : g_zero
            assign taps[i] = '0;
        end
    end

    // The pipeline moves as one unless a finished result is being held.
    assign adv = !(res_valid && res_stall);

    sc2d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pix_valid (pix_valid),
        .pixel     (pixel),
        .drain     (drain),
        .geom      (geom),
        .pix_stall (pix_stall),
        .op        (op_a),
        .window    (window)
    );

    sc2d_row_filter u_row (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .op_a   (op_a),
        .window (window),
        .taps   (taps),
        .rad    (geom.rad),
        .op_b   (op_b),
        .rf     (rf)
    );

    // One bank per stored line. A pass reads all banks at its column, and a pixel
    // pass writes its own line in the same cycle; the column stage picks the lines.
    for (genvar b = 0; b < LINE_SLOTS; b++)
    begin : g_bank
        sc2d_line_ram #(
            .DEPTH  (MAX_WIDTH),
            .DATA_W (RF_W)
        ) u_ram (
            .clk   (clk),
            .we    (adv && op_b.valid && op_b.wr && op_b.slot == SLOT_W'(b)),
            .waddr (op_b.x),
            .wdata (rf),
            .re    (adv),
            .raddr (op_b.x),
            .rdata (line[b])
        );
    end

    sc2d_col_filter u_col (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .op_b      (op_b),
        .rf        (rf),
        .line      (line),
        .taps      (taps),
        .geom      (geom),
        .res_valid (res_valid),
        .value     (value),
        .last      (last)
    );

endmodule

// ----- sv/sc2d_line_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module sc2d_line_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 28
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/sc2d_front.sv -----
// Input side: frame positions, pixel window and issue of row-filter passes.
`timescale 1ns / 1ps

module sc2d_front import sc2d_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    pix_valid,
    input  pixel_t  pixel,
    input  logic    drain,
    input  geom_t   geom,
    output logic    pix_stall,
    output op_t     op,
    output window_t window
);

    localparam int CM_W = COL_W + 1;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    window_t           win_reg, win_next;
    op_t               op_reg, op_next;
    logic              pend_reg, pend_next;
    logic [M_W-1:0]    pend_m_reg, pend_m_next;
    logic [COL_W-1:0]  pend_col_reg, pend_col_next;
    logic [ROW_W-1:0]  pend_row_reg, pend_row_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;

    logic              take, acc, in_image, do_pix, do_drn, col_last;
    logic [COL_W-1:0]  col_n;
    logic [ROW_W-1:0]  row_n, row_inc, frame_end;
    logic [SLOT_W-1:0] slot_n;
    logic [M_W-1:0]    m_sel;
    logic [COL_W-1:0]  c_sel, xw;
    logic [ROW_W-1:0]  r_sel;
    logic [SLOT_W-1:0] s_sel;
    logic [CM_W-1:0]   colm;
    logic              pos_ok, emit_ok, last_row, x_last;

    assign take      = adv && !pend_reg;
    assign acc       = pix_valid && take;
    assign pix_stall = !take;
    assign op        = op_reg;
    assign window    = win_reg;

    // Position clean-up after a size change, then the step through the frame.
    always_comb
    begin
        frame_end = ROW_W'(geom.hgt) + ROW_W'(geom.rad);
        col_n     = (WID_W'(col_reg) >= geom.wid) ? '0 : col_reg;
        row_n     = row_reg;
        slot_n    = slot_reg;
        if (row_reg >= frame_end)
        begin
            row_n  = '0;
            col_n  = '0;
            slot_n = '0;
        end
        in_image = row_n < ROW_W'(geom.hgt);
        do_pix   = acc && !drain && in_image;
        do_drn   = acc && drain && !in_image;
        col_last = (WID_W'(col_n) + WID_W'(1)) == geom.wid;
        row_inc  = row_n + 1'b1;

        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (acc)
        begin
            col_next  = col_n;
            row_next  = row_n;
            slot_next = slot_n;
        end
        if (do_pix || do_drn)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (row_inc >= frame_end)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_inc;
                    slot_next = (slot_n == SLOT_W'(LINE_SLOTS - 1)) ? '0 : slot_n + 1'b1;
                end
            end
            else
            begin
                col_next = col_n + 1'b1;
            end
        end
    end

    // Pass selection: the first pass of a new pixel, an extra pass at row end, or a drain pass.
    always_comb
    begin
        m_sel    = pend_reg ? pend_m_reg    : '0;
        c_sel    = pend_reg ? pend_col_reg  : col_n;
        r_sel    = pend_reg ? pend_row_reg  : row_n;
        s_sel    = pend_reg ? pend_slot_reg : slot_n;
        colm     = CM_W'(c_sel) + CM_W'(m_sel);
        pos_ok   = colm >= CM_W'(geom.rad);
        xw       = COL_W'(colm - CM_W'(geom.rad));
        emit_ok  = r_sel >= ROW_W'(geom.rad);
        last_row = r_sel == (frame_end - ROW_W'(1));
        x_last   = (WID_W'(xw) + WID_W'(1)) == geom.wid;

        op_next = '0;
        if (pend_reg || do_pix)
        begin
            op_next.valid = pos_ok;
            op_next.emit  = emit_ok;
            op_next.wr    = 1'b1;
            op_next.cur   = 1'b1;
            op_next.last  = last_row && x_last;
            op_next.m     = m_sel;
            op_next.x     = xw;
            op_next.row   = r_sel;
            op_next.slot  = s_sel;
        end
        else if (do_drn)
        begin
            op_next.valid = emit_ok;
            op_next.emit  = 1'b1;
            op_next.last  = last_row && col_last;
            op_next.x     = col_n;
            op_next.row   = row_n;
            op_next.slot  = slot_n;
        end
    end

    always_comb
    begin
        pend_next      = pend_reg;
        pend_m_next    = pend_m_reg;
        pend_col_next  = pend_col_reg;
        pend_row_next  = pend_row_reg;
        pend_slot_next = pend_slot_reg;
        if (pend_reg && adv)
        begin
            if (pend_m_reg == geom.rad)
            begin
                pend_next = 1'b0;
            end
            else
            begin
                pend_m_next = pend_m_reg + 1'b1;
            end
        end
        else if (do_pix && col_last && geom.rad != '0)
        begin
            pend_next      = 1'b1;
            pend_m_next    = M_W'(1);
            pend_col_next  = col_n;
            pend_row_next  = row_n;
            pend_slot_next = slot_n;
        end
    end

    always_comb
    begin
        win_next = win_reg;
        if (do_pix)
        begin
            if (col_n == '0)
            begin
                win_next = '0;
                win_next[0] = pixel;
            end
            else
            begin
                win_next = {win_reg[WIN_DEPTH-2:0], pixel};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
            win_reg    <= '0;
            op_reg     <= '0;
            pend_reg   <= 1'b0;
            pend_m_reg <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            slot_reg   <= slot_next;
            win_reg    <= win_next;
            pend_reg   <= pend_next;
            pend_m_reg <= pend_m_next;
            if (adv)
            begin
                op_reg <= op_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_col_reg  <= pend_col_next;
        pend_row_reg  <= pend_row_next;
        pend_slot_reg <= pend_slot_next;
    end

endmodule

// ----- sv/sc2d_row_filter.sv -----
// Row filter: tap products of the pixel window, registered, then their sum.
`timescale 1ns / 1ps

module sc2d_row_filter import sc2d_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  op_t            op_a,
    input  window_t        window,
    input  taps_t          taps,
    input  logic [M_W-1:0] rad,
    output op_t            op_b,
    output rf_t            rf
);

    logic [TAP_NUM+MAX_RADIUS-1:0][TAP_W-1:0] taps_ext;
    logic signed [PROD_W-1:0] prod_next [WIN_DEPTH];
    logic signed [PROD_W-1:0] prod_reg  [WIN_DEPTH];
    op_t                      op_b_reg;

    assign taps_ext = {{(MAX_RADIUS * TAP_W){1'b0}}, taps};
    assign op_b     = op_b_reg;

    // Pass m weights window entry i with tap i+m, up to tap 2R.
    always_comb
    begin
        logic [TAP_W-1:0] tsel;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            tsel = '0;
            for (int mm = 0; mm <= MAX_RADIUS; mm++)
            begin
                if (op_a.m == M_W'(mm) && (i + mm) <= 2 * int'(rad))
                begin
                    tsel = taps_ext[i + mm];
                end
            end
            prod_next[i] = op_a.cur ?
                PROD_W'($signed(tsel)) * PROD_W'($signed({1'b0, window[i]})) : '0;
        end
    end

    always_comb
    begin
        rf = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            rf = rf + RF_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_b_reg <= '0;
        end
        else if (adv)
        begin
            op_b_reg <= op_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

endmodule

// ----- sv/sc2d_col_filter.sv -----
// Column filter: products with the stored row-filtered lines, sum and result register.
`timescale 1ns / 1ps

module sc2d_col_filter import sc2d_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  op_t                     op_b,
    input  rf_t                     rf,
    input  linedata_t               line,
    input  taps_t                   taps,
    input  geom_t                   geom,
    output logic                    res_valid,
    output logic signed [VAL_W-1:0] value,
    output logic                    last
);

    op_t                      op_c_reg, op_d_reg;
    rf_t                      rf_c_reg;
    logic signed [CP_W-1:0]   cp_next [TAP_NUM];
    logic signed [CP_W-1:0]   cp_reg  [TAP_NUM];
    logic signed [VAL_W-1:0]  sum;
    logic                     res_valid_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic                     last_reg;

    assign res_valid = res_valid_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    // Distance k weights the line of row (row - k), kept only inside the image.
    always_comb
    begin
        int  s;
        logic ok;
        cp_next[0] = CP_W'($signed(taps[0])) * CP_W'(rf_c_reg);
        for (int k = 1; k < TAP_NUM; k++)
        begin
            s = int'(op_c_reg.slot) - k;
            if (s < 0)
            begin
                s = s + LINE_SLOTS;
            end
            ok = (k <= 2 * int'(geom.rad)) && (k <= int'(op_c_reg.row)) &&
                 (int'(op_c_reg.row) < int'(geom.hgt) + k);
            cp_next[k] = ok ?
                CP_W'($signed(taps[k])) * CP_W'($signed(line[SLOT_W'(s)])) : '0;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < TAP_NUM; k++)
        begin
            sum = sum + VAL_W'(cp_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_c_reg      <= '0;
            op_d_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            op_c_reg      <= op_b;
            op_d_reg      <= op_c_reg;
            res_valid_reg <= op_d_reg.valid && op_d_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rf_c_reg <= rf;
            for (int k = 0; k < TAP_NUM; k++)
            begin
                cp_reg[k] <= cp_next[k];
            end
            value_reg <= sum;
            last_reg  <= op_d_reg.last;
        end
    end

endmodule

// ----- sv/sc2d_checker.sv -----
// Port-level checker of the separable convolution block and its bind.
`timescale 1ns / 1ps
`include "separable_convolution_2d_macros.svh"

module sc2d_checker import sc2d_pkg::*; (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    pix_valid,
    input logic                    pix_stall,
    input logic                    res_valid,
    input logic                    res_stall,
    input logic signed [VAL_W-1:0] value,
    input logic                    last
);

    logic [3:0] idle_cnt_reg;

    // Counts cycles with neither an input beat nor output backpressure.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cnt_reg <= '0;
        end
        else if ((pix_valid && !pix_stall) || res_stall)
        begin
            idle_cnt_reg <= '0;
        end
        else if (idle_cnt_reg != 4'hF)
        begin
            idle_cnt_reg <= idle_cnt_reg + 1'b1;
        end
    end

    `SC2D_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(value) && $stable(last), "stalled result changed")
    `SC2D_ASSERT_NOW(a_backpressure, clk, rst_n, res_valid && res_stall, pix_stall, "pixel taken while result held")
    `SC2D_ASSERT_NOW(a_drained, clk, rst_n, idle_cnt_reg >= 4'd10, !res_valid, "result without a pending beat")

endmodule

bind separable_convolution_2d sc2d_checker u_sc2d_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the separable 2-D convolution block.
`timescale 1ns / 1ps

module tb_top;
    import sc2d_pkg::*;

    // Clock, reset and the ports of the block.
    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    pix_valid;
    logic                    pix_stall;
    logic [PIX_W-1:0]        pixel;
    logic                    drain;
    logic                    res_valid;
    logic                    res_stall;
    logic signed [VAL_W-1:0] value;
    logic                    last;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             drn;
    } beat_t;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             lst;
    } filtered_t;

    separable_convolution_2d dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pix_valid(pix_valid), .pix_stall(pix_stall),
        .pixel(pixel), .drain(drain),
        .res_valid(res_valid), .res_stall(res_stall),
        .value(value), .last(last)
    );

    // Predictor state: the register values as written and the block's own
    // internal state. Line entries that are never written are never read,
    // but they start at zero here all the same.
    logic [2:0]           reg_radius;
    logic [10:0]          reg_width;
    logic [10:0]          reg_height;
    logic [63:0]          reg_taps_lo;
    logic [7:0]           reg_tap_eight;
    logic [15:0]          pix_window [WIN_DEPTH];
    longint               line_store [LINE_SLOTS][MAX_WIDTH];
    int unsigned          cur_col;
    int unsigned          cur_row;

    beat_t                pending_beats[$];
    filtered_t            expected_pixels[$];
    int                   mismatch_count;
    int                   sender_idle_pct;
    int                   receiver_stall_pct;
    int                   quiet_cycles;
    bit                   timed_out;

    function automatic longint kernel_tap(int unsigned j);
        logic [7:0] b;
        if (j < 8) b = reg_taps_lo[8*j +: 8];
        else if (j == 8) b = reg_tap_eight;
        else return 0;
        return longint'($signed(b));
    endfunction

    function automatic longint column_filter(int unsigned r, int unsigned x, int unsigned rad,
                                             int unsigned hgt, longint cur);
        longint      s;
        int unsigned d;
        s = 0;
        d = (r >= 2*rad) ? r - 2*rad : 0;
        for (; d < r && d < hgt; d++)
            s += kernel_tap(r - d) * line_store[d % LINE_SLOTS][x];
        return s + kernel_tap(0) * cur;
    endfunction

    function automatic void push_result(longint v, bit lst);
        filtered_t f;
        f.val = v[VAL_W-1:0];
        f.lst = lst;
        expected_pixels.push_back(f);
    endfunction

    // Advances the predictor by one accepted beat and queues its results.
    function automatic void predict_beat(beat_t b);
        int unsigned rad, wid, hgt, row, col, mmax, x;
        longint      rf;
        rad = (reg_radius > MAX_RADIUS) ? MAX_RADIUS : reg_radius;
        wid = (reg_width < 1) ? 1 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
        hgt = (reg_height < 1) ? 1 : (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : reg_height;
        if (cur_col >= wid) cur_col = 0;
        if (cur_row >= hgt + rad) begin
            cur_row = 0;
            cur_col = 0;
        end
        row = cur_row;
        col = cur_col;
        if (b.drn) begin
            if (row < hgt) return;
            if (row >= rad)
                push_result(column_filter(row, col, rad, hgt, 0),
                            (row - rad == hgt - 1) && (col == wid - 1));
        end else begin
            if (row >= hgt) return;
            if (col == 0)
                for (int i = 0; i < WIN_DEPTH; i++) pix_window[i] = '0;
            for (int i = WIN_DEPTH - 1; i > 0; i--) pix_window[i] = pix_window[i-1];
            pix_window[0] = b.pix;
            mmax = (col == wid - 1) ? rad : 0;
            for (int unsigned m = 0; m <= mmax; m++) begin
                if (col + m < rad) continue;
                x = col + m - rad;
                rf = 0;
                for (int unsigned j = m; j <= 2*rad; j++)
                    rf += kernel_tap(j) * longint'(pix_window[j-m]);
                if (row >= rad)
                    push_result(column_filter(row, x, rad, hgt, rf),
                                (row - rad == hgt - 1) && (x == wid - 1));
                line_store[row % LINE_SLOTS][x] = rf;
            end
        end
        cur_col = col + 1;
        if (cur_col >= wid) begin
            cur_col = 0;
            cur_row = row + 1;
            if (cur_row >= hgt + rad) cur_row = 0;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: presents queued beats, idling at random. A beat stays on the
    // bus until it is accepted, so valid only drops after acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pixel     <= '0;
            drain     <= 1'b0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
                predict_beat('{pix: pixel, drn: drain});
            if (!pix_valid || !pix_stall)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    pix_valid <= 1'b1;
                    pixel     <= pending_beats[0].pix;
                    drain     <= pending_beats[0].drn;
                    void'(pending_beats.pop_front());
                end
                else
                    pix_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation
    // and randomizes the result stall for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: value=%0d last=%0b", value, last);
                end
                else if (expected_pixels[0].val !== value || expected_pixels[0].lst !== last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
                                 $signed(expected_pixels[0].val), expected_pixels[0].lst,
                                 value, last);
                    void'(expected_pixels.pop_front());
                end
                else
                    void'(expected_pixels.pop_front());
            end
            res_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Watchdog: counts cycles with no beat accepted on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end

    // Writes one register while the block is idle and mirrors it.
    task automatic write_reg(cfg_reg_t idx, logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:    reg_radius    = data[2:0];
            REG_WIDTH:     reg_width     = data[10:0];
            REG_HEIGHT:    reg_height    = data[10:0];
            REG_TAPS_LO:   reg_taps_lo   = data;
            REG_TAP_EIGHT: reg_tap_eight = data[7:0];
            default: ;
        endcase
    endtask

    task automatic setup_frame(int rad, int wid, int hgt, logic [63:0] taps, logic [7:0] t8);
        write_reg(REG_RADIUS, 64'(rad));
        write_reg(REG_WIDTH, 64'(wid));
        write_reg(REG_HEIGHT, 64'(hgt));
        write_reg(REG_TAPS_LO, taps);
        write_reg(REG_TAP_EIGHT, 64'(t8));
    endtask

    // Waits until every queued beat is sent and every result has come back.
    task automatic wait_idle();
        while ((pending_beats.size() > 0 || pix_valid || expected_pixels.size() > 0)
               && !timed_out)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Queues a whole frame with its drain rows, with stray drain or pixel beats at random.
    task automatic queue_frame(int rad, int wid, int hgt);
        for (int i = 0; i < wid * hgt; i++)
        begin
            if ($urandom_range(19) == 0)
                pending_beats.push_back('{pix: random_pixel(), drn: 1'b1});
            pending_beats.push_back('{pix: random_pixel(), drn: 1'b0});
        end
        for (int i = 0; i < rad * wid; i++)
        begin
            if ($urandom_range(19) == 0)
                pending_beats.push_back('{pix: random_pixel(), drn: 1'b0});
            pending_beats.push_back('{pix: random_pixel(), drn: 1'b1});
        end
    endtask

    function automatic logic [63:0] random_taps();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        int phase_items;
        int rad;
        int wid;
        int hgt;
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        mismatch_count     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        timed_out          = 1'b0;
        quiet_cycles       = 0;
        reg_radius         = 3'd1;
        reg_width          = 11'd1024;
        reg_height         = 11'd1024;
        reg_taps_lo        = '0;
        reg_tap_eight      = '0;
        cur_col            = 0;
        cur_row            = 0;
        for (int i = 0; i < WIN_DEPTH; i++) pix_window[i] = '0;
        for (int s = 0; s < LINE_SLOTS; s++)
            for (int x = 0; x < MAX_WIDTH; x++) line_store[s][x] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A tiny 3x3 frame with extreme taps and pixels, a
        // stray drain inside the image and a stray pixel while draining.
        setup_frame(1, 3, 3, 64'h0000_0000_0080_7F80, 8'h7F);
        pending_beats.push_back('{pix: 16'hFFFF, drn: 1'b0});
        pending_beats.push_back('{pix: 16'h1234, drn: 1'b1});
        pending_beats.push_back('{pix: 16'h0000, drn: 1'b0});
        for (int i = 0; i < 7; i++)
            pending_beats.push_back('{pix: 16'hFFFF, drn: 1'b0});
        pending_beats.push_back('{pix: 16'hAAAA, drn: 1'b1});
        pending_beats.push_back('{pix: 16'h5555, drn: 1'b0});
        pending_beats.push_back('{pix: 16'hFFFF, drn: 1'b1});
        pending_beats.push_back('{pix: 16'h0000, drn: 1'b1});
        wait_idle();

        // Radius zero with a single pixel frame: the frame ends on the image.
        setup_frame(0, 1, 1, 64'hFFFF_FFFF_FFFF_FF81, 8'h80);
        pending_beats.push_back('{pix: 16'hFFFF, drn: 1'b0});
        pending_beats.push_back('{pix: 16'h8001, drn: 1'b0});
        wait_idle();

        // Out-of-range registers: radius clamps to the maximum, a zero width
        // and height clamp to one. All nine taps at the negative extreme.
        setup_frame(7, 0, 0, 64'h8080_8080_8080_8080, 8'h80);
        queue_frame(MAX_RADIUS, 1, 1);
        wait_idle();

        // Random phases, each with its own idling mix and frame geometry.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
                default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
            endcase
            phase_items = 0;
            while (phase_items < 18)
            begin
                rad = $urandom_range(MAX_RADIUS);
                wid = $urandom_range(1, 6);
                hgt = $urandom_range(1, 4);
                setup_frame(rad, wid, hgt, random_taps(), 8'($urandom_range(255)));
                queue_frame(rad, wid, hgt);
                phase_items += wid * (hgt + rad);
                wait_idle();
            end
        end

        if (timed_out)
            $display("Testbench completed WITH ERRORS");
        else if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Ends a hung run.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT + 1)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/sc2d_pkg.sv
sv/sc2d_line_ram.sv
sv/sc2d_front.sv
sv/sc2d_row_filter.sv
sv/sc2d_col_filter.sv
sv/separable_convolution_2d.sv
sv/sc2d_checker.sv
verif/tb_top.sv
